// File: src/assert_macros.svh
// Assertion macros for the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define CSS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define CSS_ASSERT(label, prop)
`define CSS_ASSERT_ALWAYS(label, prop)
`endif
`endif

// File: src/css_tok_pkg.sv
// Types and constants shared by the style-sheet tokenizer modules.
package css_tok_pkg;

  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_NUMBER = 4'd1,
    KIND_HEX    = 4'd2,
    KIND_HASH   = 4'd3,
    KIND_COLON  = 4'd4,
    KIND_SEMI   = 4'd5,
    KIND_DOT    = 4'd6,
    KIND_OPEN   = 4'd7,
    KIND_CLOSE  = 4'd8,
    KIND_AT     = 4'd9
  } tok_kind_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DASH  = 8'h2d;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] tbyte;
    logic       bvalid;
    logic       starts;
    logic       ends;
    logic       last;
  } tok_t;

  // Up to two token events produced by one request.
  typedef struct packed {
    logic [1:0] num;
    tok_t       first;
    tok_t       second;
  } tok_push_t;

endpackage

// File: src/css_tok_scan.sv
// Tokenizer state and per-byte classification logic.
module css_tok_scan (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [7:0]             text_byte_i,
  input  logic                   end_of_text_i,
  output css_tok_pkg::tok_push_t push_o
);
  import css_tok_pkg::*;

  typedef enum logic [1:0] {
    OPEN_NONE   = 2'd0,
    OPEN_IDENT  = 2'd1,
    OPEN_NUMBER = 2'd2,
    OPEN_HEX    = 2'd3
  } open_e;

  logic  in_comment_q, in_comment_d;
  logic  slash_q, slash_d;
  logic  star_q, star_d;
  logic  hash_q, hash_d;
  open_e open_q, open_d;

  logic  pre_v, main_v;
  tok_t  pre_t, main_t;
  logic  is_letter, is_digit, is_hex, cont;
  logic [7:0] b;

  function automatic tok_kind_e kind_of_open(open_e o);
    tok_kind_e k;
    case (o)
      OPEN_IDENT:  k = KIND_IDENT;
      OPEN_NUMBER: k = KIND_NUMBER;
      OPEN_HEX:    k = KIND_HEX;
      default:     k = KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic tok_t mk(tok_kind_e k, logic [7:0] c, logic v, logic s, logic e);
    tok_t t;
    t.kind   = k;
    t.tbyte  = c;
    t.bvalid = v;
    t.starts = s;
    t.ends   = e;
    t.last   = 1'b0;
    return t;
  endfunction

  assign b         = text_byte_i;
  assign is_letter = (b inside {[8'h61:8'h7a], [8'h41:8'h5a]});
  assign is_digit  = (b inside {[8'h30:8'h39]});
  assign is_hex    = is_digit || (b inside {[8'h61:8'h66], [8'h41:8'h46]});

  always_comb begin
    case (open_q)
      OPEN_IDENT:  cont = is_letter || is_digit || (b == CH_DASH);
      OPEN_NUMBER: cont = is_digit;
      OPEN_HEX:    cont = is_hex;
      default:     cont = 1'b0;
    endcase
  end

  always_comb begin
    in_comment_d = in_comment_q;
    slash_d      = slash_q;
    star_d       = star_q;
    hash_d       = hash_q;
    open_d       = open_q;
    pre_v        = 1'b0;
    main_v       = 1'b0;
    pre_t        = mk(KIND_IDENT, CH_NUL, 1'b0, 1'b0, 1'b0);
    main_t       = mk(KIND_IDENT, CH_NUL, 1'b0, 1'b0, 1'b0);

    if (end_of_text_i || (b == CH_NUL)) begin
      if (open_q != OPEN_NONE) begin
        pre_v = 1'b1;
        pre_t = mk(kind_of_open(open_q), CH_NUL, 1'b0, 1'b0, 1'b1);
      end
      if (hash_q) begin
        main_v = 1'b1;
        main_t = mk(KIND_HASH, CH_HASH, 1'b1, 1'b1, 1'b1);
      end
      in_comment_d = 1'b0;
      slash_d      = 1'b0;
      star_d       = 1'b0;
      hash_d       = 1'b0;
      open_d       = OPEN_NONE;
    end else if (in_comment_q) begin
      if (star_q && (b == CH_SLASH)) begin
        in_comment_d = 1'b0;
        star_d       = 1'b0;
      end else begin
        star_d = (b == CH_STAR);
      end
    end else if (slash_q && (b == CH_STAR)) begin
      slash_d      = 1'b0;
      in_comment_d = 1'b1;
      star_d       = 1'b0;
    end else begin
      slash_d = 1'b0;
      hash_d  = 1'b0;
      if (hash_q && is_hex) begin
        main_v = 1'b1;
        main_t = mk(KIND_HEX, b, 1'b1, 1'b1, 1'b0);
        open_d = OPEN_HEX;
      end else begin
        // A held hash implies no token is open, so at most one early event.
        if (hash_q) begin
          pre_v = 1'b1;
          pre_t = mk(KIND_HASH, CH_HASH, 1'b1, 1'b1, 1'b1);
        end
        if ((open_q != OPEN_NONE) && cont) begin
          main_v = 1'b1;
          main_t = mk(kind_of_open(open_q), b, 1'b1, 1'b0, 1'b0);
        end else begin
          if (open_q != OPEN_NONE) begin
            pre_v = 1'b1;
            pre_t = mk(kind_of_open(open_q), CH_NUL, 1'b0, 1'b0, 1'b1);
          end
          open_d = OPEN_NONE;
          case (b)
            CH_SLASH:  slash_d = 1'b1;
            CH_HASH:   hash_d = 1'b1;
            CH_COLON:  begin
              main_v = 1'b1;
              main_t = mk(KIND_COLON, b, 1'b1, 1'b1, 1'b1);
            end
            CH_SEMI:   begin
              main_v = 1'b1;
              main_t = mk(KIND_SEMI, b, 1'b1, 1'b1, 1'b1);
            end
            CH_DOT:    begin
              main_v = 1'b1;
              main_t = mk(KIND_DOT, b, 1'b1, 1'b1, 1'b1);
            end
            CH_LBRACE: begin
              main_v = 1'b1;
              main_t = mk(KIND_OPEN, b, 1'b1, 1'b1, 1'b1);
            end
            CH_RBRACE: begin
              main_v = 1'b1;
              main_t = mk(KIND_CLOSE, b, 1'b1, 1'b1, 1'b1);
            end
            CH_AT:     begin
              main_v = 1'b1;
              main_t = mk(KIND_AT, b, 1'b1, 1'b1, 1'b1);
            end
            default:   begin
              if (is_letter || (b == CH_DASH)) begin
                main_v = 1'b1;
                main_t = mk(KIND_IDENT, b, 1'b1, 1'b1, 1'b0);
                open_d = OPEN_IDENT;
              end else if (is_digit) begin
                main_v = 1'b1;
                main_t = mk(KIND_NUMBER, b, 1'b1, 1'b1, 1'b0);
                open_d = OPEN_NUMBER;
              end
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    push_o.num    = {1'b0, pre_v} + {1'b0, main_v};
    push_o.first  = pre_v ? pre_t : main_t;
    push_o.second = main_t;
    if (pre_v && main_v) begin
      push_o.second.last = 1'b1;
    end else begin
      push_o.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q <= 1'b0;
      slash_q      <= 1'b0;
      star_q       <= 1'b0;
      hash_q       <= 1'b0;
      open_q       <= OPEN_NONE;
    end else if (fire_i) begin
      in_comment_q <= in_comment_d;
      slash_q      <= slash_d;
      star_q       <= star_d;
      hash_q       <= hash_d;
      open_q       <= open_d;
    end
  end

endmodule

// File: src/css_tok_fifo.sv
// Result queue that takes up to two token events a cycle and emits one unless out_stall_i is set.
module css_tok_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_en_i,
  input  css_tok_pkg::tok_push_t              push_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output css_tok_pkg::tok_t                   out_tok_o,
  output logic [css_tok_pkg::FifoCntW-1:0]    count_o
);
  import css_tok_pkg::*;

  tok_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] rd_q, rd_d;
  logic [FifoPtrW-1:0] wr_q, wr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoPtrW-1:0] wr_next;
  logic [1:0]          num;
  logic                pop;

  assign num     = push_en_i ? push_i.num : 2'd0;
  assign pop     = (cnt_q != '0) && !out_stall_i;
  assign wr_next = wr_q + FifoPtrW'(1);

  assign rd_d  = pop ? rd_q + FifoPtrW'(1) : rd_q;
  assign wr_d  = wr_q + FifoPtrW'(num);
  assign cnt_d = cnt_q + FifoCntW'(num) - FifoCntW'(pop);

  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rd_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

endmodule

// File: src/css_byte_tokenizer.sv
// Style-sheet byte tokenizer: input register, scan logic and result queue.
// A request accepted into the input register is scanned, and its results go into the queue.
// Throughput: one request per cycle when each causes at most one result and the output
// is not stalled; a request with two results is bounded by the one-result-per-cycle queue.
// Reset is asynchronous and active low; it clears the tokenizer state and
// empties the input register and the result queue.
`include "assert_macros.svh"
module css_byte_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       byte_valid_o,
  output logic       starts_token_o,
  output logic       ends_token_o,
  output logic       last_of_run_o
);
  import css_tok_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [7:0]          byte_q;
  logic                eot_q;
  logic                accept;
  logic                advance;
  logic                fire;
  tok_push_t           push;
  tok_t                out_tok;
  logic [FifoCntW-1:0] count;

  assign advance    = (count <= FifoCntW'(FifoDepth - 2));
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_valid_d = accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
  end

  css_tok_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .text_byte_i   (byte_q),
    .end_of_text_i (eot_q),
    .push_o        (push)
  );

  css_tok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (fire),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_tok_o   (out_tok),
    .count_o     (count)
  );

  assign token_kind_o   = out_tok.kind;
  assign token_byte_o   = out_tok.tbyte;
  assign byte_valid_o   = out_tok.bvalid;
  assign starts_token_o = out_tok.starts;
  assign ends_token_o   = out_tok.ends;
  assign last_of_run_o  = out_tok.last;

  `CSS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_stall_o)
  `CSS_ASSERT(a_fifo_bound, count <= FifoCntW'(FifoDepth))
  `CSS_ASSERT(a_stall_when_full, in_stall_o |-> count > FifoCntW'(FifoDepth - 2))
  `CSS_ASSERT(a_run_continues, out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)

endmodule

// File: dv/tb_css_byte_tokenizer.sv
`timescale 1ns / 100ps
// Self-checking testbench for css_byte_tokenizer with a scoreboard that predicts token events.
module tb_css_byte_tokenizer;
  import css_tok_pkg::*;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_IDENT  = 2'd1,
    RUN_NUMBER = 2'd2,
    RUN_HEX    = 2'd3
  } run_e;

  class token_scoreboard;
    tok_t        pending_tokens[$];
    bit          in_comment = 1'b0;
    bit          slash_seen = 1'b0;
    bit          star_seen  = 1'b0;
    bit          hash_held  = 1'b0;
    run_e        run        = RUN_NONE;
    int unsigned requests   = 0;
    int unsigned results    = 0;
    int unsigned errors     = 0;

    task report(input string msg);
      errors++;
      if (errors <= 25) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function bit continues_run(logic [7:0] c);
      case (run)
        RUN_IDENT:  return is_letter(c) || c == CH_DASH || is_digit(c);
        RUN_NUMBER: return is_digit(c);
        RUN_HEX:    return is_hex(c);
        default:    return 1'b0;
      endcase
    endfunction

    function tok_kind_e run_kind();
      case (run)
        RUN_IDENT:  return KIND_IDENT;
        RUN_NUMBER: return KIND_NUMBER;
        default:    return KIND_HEX;
      endcase
    endfunction

    function bit punct_of(logic [7:0] c, output tok_kind_e k);
      k = KIND_COLON;
      case (c)
        CH_COLON:  k = KIND_COLON;
        CH_SEMI:   k = KIND_SEMI;
        CH_DOT:    k = KIND_DOT;
        CH_LBRACE: k = KIND_OPEN;
        CH_RBRACE: k = KIND_CLOSE;
        CH_AT:     k = KIND_AT;
        default:   return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void add(tok_kind_e k, logic [7:0] ch, bit bv, bit st, bit en);
      tok_t t;
      t.kind   = k;
      t.tbyte  = ch;
      t.bvalid = bv;
      t.starts = st;
      t.ends   = en;
      t.last   = 1'b0;
      pending_tokens.push_back(t);
    endfunction

    function void close_run();
      if (run != RUN_NONE) begin
        add(run_kind(), 8'h00, 1'b0, 1'b0, 1'b1);
        run = RUN_NONE;
      end
    endfunction

    function void release_hash();
      if (hash_held) begin
        add(KIND_HASH, CH_HASH, 1'b1, 1'b1, 1'b1);
        hash_held = 1'b0;
      end
    endfunction

    function void scan_byte(logic [7:0] c);
      tok_kind_e pk;
      if (hash_held) begin
        hash_held = 1'b0;
        if (is_hex(c)) begin
          add(KIND_HEX, c, 1'b1, 1'b1, 1'b0);
          run = RUN_HEX;
          return;
        end
        add(KIND_HASH, CH_HASH, 1'b1, 1'b1, 1'b1);
      end
      if (run != RUN_NONE && continues_run(c)) begin
        add(run_kind(), c, 1'b1, 1'b0, 1'b0);
        return;
      end
      close_run();
      if (c == CH_SLASH) begin
        slash_seen = 1'b1;
      end else if (c == CH_HASH) begin
        hash_held = 1'b1;
      end else if (punct_of(c, pk)) begin
        add(pk, c, 1'b1, 1'b1, 1'b1);
      end else if (is_letter(c) || c == CH_DASH) begin
        add(KIND_IDENT, c, 1'b1, 1'b1, 1'b0);
        run = RUN_IDENT;
      end else if (is_digit(c)) begin
        add(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0);
        run = RUN_NUMBER;
      end
    endfunction

    function void note_request(logic [7:0] ch, logic eot);
      int   depth_before;
      tok_t t;
      depth_before = pending_tokens.size();
      requests++;
      if (eot || ch == CH_NUL) begin
        close_run();
        release_hash();
        in_comment = 1'b0;
        slash_seen = 1'b0;
        star_seen  = 1'b0;
        hash_held  = 1'b0;
        run        = RUN_NONE;
      end else if (in_comment) begin
        if (star_seen && ch == CH_SLASH) begin
          in_comment = 1'b0;
          star_seen  = 1'b0;
        end else begin
          star_seen = (ch == CH_STAR);
        end
      end else if (slash_seen && ch == CH_STAR) begin
        slash_seen = 1'b0;
        in_comment = 1'b1;
        star_seen  = 1'b0;
      end else begin
        slash_seen = 1'b0;
        scan_byte(ch);
      end
      if (pending_tokens.size() > depth_before) begin
        t = pending_tokens.pop_back();
        t.last = 1'b1;
        pending_tokens.push_back(t);
      end
    endfunction

    task check_event(input tok_t got);
      tok_t exp;
      if (pending_tokens.size() == 0) begin
        report($sformatf("unexpected token event kind %0d byte %02h", got.kind, got.tbyte));
      end else begin
        exp = pending_tokens.pop_front();
        results++;
        if (got !== exp) begin
          report($sformatf(
            "event %0d: exp kind %0d byte %02h v%0b s%0b e%0b l%0b, got %0d %02h %0b %0b %0b %0b",
            results, exp.kind, exp.tbyte, exp.bvalid, exp.starts, exp.ends, exp.last,
            got.kind, got.tbyte, got.bvalid, got.starts, got.ends, got.last));
        end
      end
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] text_byte_i;
  logic       end_of_text_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [3:0] token_kind_o;
  logic [7:0] token_byte_o;
  logic       byte_valid_o;
  logic       starts_token_o;
  logic       ends_token_o;
  logic       last_of_run_o;

  token_scoreboard sb;
  tok_t            seen_token;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  bit              hold_req = 1'b0;
  int              hold_left = 0;
  int              sent = 0;
  string           hex_chars = "0123456789abcdefABCDEF";

  css_byte_tokenizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_byte_o   (token_byte_o),
    .byte_valid_o   (byte_valid_o),
    .starts_token_o (starts_token_o),
    .ends_token_o   (ends_token_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_token.kind   = tok_kind_e'(token_kind_o);
      seen_token.tbyte  = token_byte_o;
      seen_token.bvalid = byte_valid_o;
      seen_token.starts = starts_token_o;
      seen_token.ends   = ends_token_o;
      seen_token.last   = last_of_run_o;
      sb.check_event(seen_token);
    end
  end

  task automatic send_request(input logic [7:0] ch, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    text_byte_i   <= ch;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(ch, eot);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_text_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 26) begin
      return $urandom_range(1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
    end
    if (pick < 44) return 8'($urandom_range(48, 57));
    if (pick < 54) begin
      case ($urandom_range(5))
        0:       return CH_COLON;
        1:       return CH_SEMI;
        2:       return CH_DOT;
        3:       return CH_LBRACE;
        4:       return CH_RBRACE;
        default: return CH_AT;
      endcase
    end
    if (pick < 60) return CH_HASH;
    if (pick < 64) return CH_DASH;
    if (pick < 71) begin
      case ($urandom_range(2))
        0:       return 8'h20;
        1:       return 8'h09;
        default: return 8'h0a;
      endcase
    end
    if (pick < 76) return CH_SLASH;
    if (pick < 80) return CH_STAR;
    if (pick < 98) return 8'($urandom_range(1, 255));
    return CH_NUL;
  endfunction

  function automatic logic [7:0] ident_byte();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(48, 57));
      1:       return CH_DASH;
      2:       return 8'($urandom_range(65, 90));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  task automatic send_random_unit();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_request($urandom_range(3) == 0 ? CH_DASH : 8'($urandom_range(97, 122)), 1'b0);
      n = $urandom_range(7);
      repeat (n) send_request(ident_byte(), 1'b0);
      send_request(random_text_byte(), 1'b0);
    end else if (pick < 45) begin
      n = $urandom_range(1, 6);
      repeat (n) send_request(8'($urandom_range(48, 57)), 1'b0);
    end else if (pick < 55) begin
      send_request(CH_HASH, 1'b0);
      n = $urandom_range(1) ? 6 : 3;
      repeat (n) send_request(hex_chars[$urandom_range(21)], 1'b0);
    end else if (pick < 63) begin
      send_request(CH_SLASH, 1'b0);
      send_request(CH_STAR, 1'b0);
      n = $urandom_range(8);
      repeat (n) begin
        case ($urandom_range(2))
          0:       send_request(CH_STAR, 1'b0);
          1:       send_request(CH_SLASH, 1'b0);
          default: send_request(8'($urandom_range(1, 255)), 1'b0);
        endcase
      end
      send_request(CH_STAR, 1'b0);
      send_request(CH_SLASH, 1'b0);
    end else if (pick < 66) begin
      send_request(8'($urandom_range(255)), 1'b1);
    end else begin
      send_request(random_text_byte(), 1'b0);
    end
  endtask

  initial begin
    string directed_text;
    int    target;
    in_valid_i    = 1'b0;
    text_byte_i   = 8'h00;
    end_of_text_i = 1'b0;
    rst_ni        = 1'b0;
    sb            = new;
    directed_text = "#Afg-9:##z\t07/x/*/*/;.{}@ \n";
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < directed_text.len(); i++) send_request(directed_text[i], 1'b0);
    send_request(8'hff, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(CH_HASH, 1'b0);
    send_request(8'hff, 1'b1);
    send_request("5", 1'b0);
    send_request(CH_NUL, 1'b0);
    send_request(CH_SLASH, 1'b0);
    send_request(CH_STAR, 1'b0);
    send_request("a", 1'b1);

    target = sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      target += 250;
      while (sent < target) send_random_unit();
    end
    in_valid_i <= 1'b0;

    while (sb.pending_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d token events.", sb.requests, sb.results);
    $display("Covered comments, hex colors, held hashes, end markers and a long output hold.");
    if (sb.errors == 0 && sb.pending_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/css_tok_pkg.sv
src/css_tok_scan.sv
src/css_tok_fifo.sv
src/css_byte_tokenizer.sv
dv/tb_css_byte_tokenizer.sv
